### hdl/bul_pkg.sv
// bul_pkg: shared types and constants for the bounded unique ordered list.
// Used by bul_cell, bul_ctrl and bounded_unique_ordered_list. No dependencies.

package bul_pkg;

   localparam int KEY_W        = 32;
   localparam int IDX_W        = 8;
   localparam int OP_W         = 3;
   localparam int CNT_OUT_W    = 6;
   localparam int CAPACITY_DEF = 32;
   // signed width for index and count arithmetic (covers counts up to 511)
   localparam int CALC_W       = 10;

   localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
   localparam logic [OP_W-1:0] OP_REM_IDX = 3'd1;
   localparam logic [OP_W-1:0] OP_REM_KEY = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [KEY_W-1:0]        key;
      logic signed [IDX_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic                 hit;
      logic [KEY_W-1:0]     read_key;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

endpackage

### hdl/bul_cell.sv
// bul_cell: one slot of the list; takes its neighbor's key on every shift.
// Depends on bul_pkg.

module bul_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic [bul_pkg::KEY_W-1:0] nbr_key,
   output logic [bul_pkg::KEY_W-1:0] slot_key
);

   logic [bul_pkg::KEY_W-1:0] key_ff, key_in;

   always_comb begin
      key_in = key_ff;
      if (shift) begin
         key_in = nbr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign slot_key = key_ff;

endmodule

### hdl/bul_ctrl.sv
// bul_ctrl: sequencer for the cell ring. Walks the ring once per word, picks
// the key fed back into the tail cell, holds the count and the result word.
// Depends on bul_pkg.

module bul_ctrl #(
   parameter int CAPACITY = bul_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bul_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bul_pkg::rsp_type          rsp_data,
   input  logic [bul_pkg::KEY_W-1:0] head_key,
   input  logic [bul_pkg::KEY_W-1:0] next_key,
   output logic                      shift,
   output logic [bul_pkg::KEY_W-1:0] tail_key
);

   localparam int TW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic signed [bul_pkg::CALC_W-1:0] ONE_S = 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_type;

   state_type                   state_ff, state_in;
   logic [bul_pkg::OP_W-1:0]    op_ff, op_in;
   logic [bul_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [TW-1:0]               pos_ff, pos_in;
   logic                        pos_ok_ff, pos_ok_in;
   logic [TW-1:0]               step_ff, step_in;
   logic                        hit_ff, hit_in;
   logic [bul_pkg::KEY_W-1:0]   rkey_ff, rkey_in;
   logic [CW-1:0]               count_ff, count_in;
   bul_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic signed [bul_pkg::CALC_W-1:0] sidx, scnt, sclamp;
   logic in_use, match, room, at_tail, more_after, first;

   always_comb begin
      sidx       = bul_pkg::CALC_W'(req_data.index);
      scnt       = signed'(bul_pkg::CALC_W'(count_ff));
      sclamp     = (sidx >= scnt) ? (scnt - ONE_S) : sidx;
      if (sclamp < 0) begin
         sclamp = '0;
      end
      in_use     = CW'(step_ff) < count_ff;
      at_tail    = CW'(step_ff) == count_ff;
      more_after = ({1'b0, CW'(step_ff)} + (CW+1)'(1)) < {1'b0, count_ff};
      room       = count_ff < CW'(CAPACITY);
      match      = in_use && (head_key == key_ff);
      first      = !hit_ff && match;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      pos_ok_in    = pos_ok_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      rkey_in      = rkey_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      shift        = 1'b0;
      tail_key     = head_key;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_data.op;
               key_in    = req_data.key;
               step_in   = '0;
               hit_in    = 1'b0;
               rkey_in   = '0;
               pos_ok_in = (sidx >= 0) && (sidx < scnt);
               pos_in    = (req_data.op == bul_pkg::OP_READ) ? sclamp[TW-1:0]
                                                             : sidx[TW-1:0];
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            shift = 1'b1;
            case (op_ff)
               bul_pkg::OP_ADD: begin
                  if (room && match) begin
                     hit_in = 1'b1;
                  end
                  if (room && at_tail && !hit_ff) begin
                     tail_key = key_ff;
                  end
               end
               bul_pkg::OP_REM_IDX: begin
                  if (pos_ok_ff && (step_ff >= pos_ff) && more_after) begin
                     tail_key = next_key;
                  end
               end
               bul_pkg::OP_REM_KEY: begin
                  if (first) begin
                     hit_in = 1'b1;
                  end
                  if ((hit_ff || first) && more_after) begin
                     tail_key = next_key;
                  end
               end
               bul_pkg::OP_READ: begin
                  if (step_ff == pos_ff) begin
                     rkey_in = head_key;
                  end
               end
               default: begin
               end
            endcase
            step_in = step_ff + TW'(1);
            if (step_ff == TW'(CAPACITY - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.ok       = 1'b1;
               rsp_in.hit      = 1'b0;
               rsp_in.read_key = '0;
               case (op_ff)
                  bul_pkg::OP_ADD: begin
                     rsp_in.ok  = room;
                     rsp_in.hit = hit_ff;
                     if (room && !hit_ff) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bul_pkg::OP_REM_IDX: begin
                     rsp_in.hit = pos_ok_ff;
                     if (pos_ok_ff) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bul_pkg::OP_REM_KEY: begin
                     rsp_in.hit = hit_ff;
                     if (hit_ff) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bul_pkg::OP_READ: begin
                     rsp_in.read_key = rkey_ff;
                  end
                  bul_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_in.entry_count = bul_pkg::CNT_OUT_W'(count_in);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      pos_ok_ff <= pos_ok_in;
      step_ff   <= step_in;
      hit_ff    <= hit_in;
      rkey_ff   <= rkey_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not loaded into result register");

   a_fail_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.ok) |-> (count_ff == CW'(CAPACITY)))
      else $error("failed add with room left");

   a_hit_ops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && hit_ff)
      |-> (op_ff == bul_pkg::OP_ADD || op_ff == bul_pkg::OP_REM_KEY))
      else $error("search hit on an op without a search");

endmodule

### hdl/bounded_unique_ordered_list.sv
// bounded_unique_ordered_list: top level; a ring of bul_cell slots run by bul_ctrl.
// Depends on bul_pkg, bul_cell, bul_ctrl.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data (op, key, index)
//   rsp      out        rsp_valid/rsp_ready   rsp_data (ok, hit, read_key, entry_count)
//
// Each word runs in steps: accept, one full rotation of the cell ring
// (one slot reaches the head cell per cycle), then posting of the result.
// Reset clears all slots and the count at once; no sweep follows.
// A new word is accepted while the previous result waits; the ring holds its
// finished result until the result register is free.

module bounded_unique_ordered_list #(
   parameter int CAPACITY = bul_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bul_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bul_pkg::rsp_type rsp_data
);

   logic [bul_pkg::KEY_W-1:0] slot_key [CAPACITY];
   logic [bul_pkg::KEY_W-1:0] tail_key;
   logic                      shift;

   bul_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .head_key  (slot_key[0]),
      .next_key  (slot_key[1]),
      .shift     (shift),
      .tail_key  (tail_key)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_tail
         bul_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .nbr_key  (tail_key),
            .slot_key (slot_key[i])
         );
      end else begin : g_body
         bul_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .nbr_key  (slot_key[i+1]),
            .slot_key (slot_key[i])
         );
      end
   end

endmodule
